// ===== sv/mhft_pkg.sv =====
// Shared constants and types for the multicast hash filter table.
// No dependencies; used by mhft_crc_unit and multicast_hash_filter_table.
`default_nettype none

package mhft_pkg;

	localparam int unsigned MacBits   = 48;
	localparam int unsigned CrcBits   = 32;
	localparam int unsigned IdxBits   = 6;
	localparam int unsigned TableBits = 64;
	localparam int unsigned HashShift = 26;
	localparam int unsigned CntBits   = $clog2(MacBits);

	localparam logic [CrcBits-1:0] CrcPoly = 32'h04C1_1DB7;
	localparam logic [CrcBits-1:0] CrcSeed = 32'hFFFF_FFFF;

	// item kinds
	localparam logic KindClear = 1'b0;
	localparam logic KindAdd   = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_HASH  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	// sequencer to CRC unit
	typedef struct packed {
		logic load;
	} crc_ctrl_t;

	// CRC unit to sequencer
	typedef struct packed {
		logic busy;
		logic last;
	} crc_stat_t;

endpackage

`default_nettype wire

// ===== sv/mhft_crc_unit.sv =====
// Bit-serial CRC-32 engine: one address bit per cycle, LSB of byte 0 first.
// Depends on mhft_pkg.
`default_nettype none

module mhft_crc_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mhft_pkg::crc_ctrl_t           ctrl,
	input  wire logic [mhft_pkg::MacBits-1:0]  mac_address,
	output mhft_pkg::crc_stat_t                stat,
	output logic      [mhft_pkg::IdxBits-1:0]  hash_index
);

	logic [mhft_pkg::CrcBits-1:0] crc_q;
	logic [mhft_pkg::MacBits-1:0] data_q;
	logic [mhft_pkg::CntBits-1:0] cnt_q;
	logic                         busy_q;
	logic                         fb;
	logic                         last;

	assign fb   = crc_q[mhft_pkg::CrcBits-1] ^ data_q[0];
	assign last = busy_q && (cnt_q == mhft_pkg::CntBits'(mhft_pkg::MacBits - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			crc_q  <= mhft_pkg::CrcSeed;
			data_q <= mac_address;
		end else if (busy_q) begin
			crc_q  <= {crc_q[mhft_pkg::CrcBits-2:0], 1'b0} ^
			          (fb ? mhft_pkg::CrcPoly : '0);
			data_q <= data_q >> 1;
		end
	end

	assign stat.busy  = busy_q;
	assign stat.last  = last;
	assign hash_index = crc_q[mhft_pkg::HashShift +: mhft_pkg::IdxBits];

endmodule

`default_nettype wire

// ===== sv/multicast_hash_filter_table.sv =====
// Multicast hash filter table: top level with sequencer, filter and result register.
// Depends on mhft_pkg and mhft_crc_unit.
`default_nettype none

// Channel  Signals                                   Direction
// -------  ----------------------------------------  ---------
// in       in_valid, in_stall, kind, mac_address     into block
// out      out_valid, out_stall, hash_index,         out of block
//          filter_table
//
// An add goes through the hash state, where mhft_crc_unit runs the
// bit-serial CRC one address bit per cycle, then to the write state.
// A clear goes straight to the write state. in_stall is high from acceptance
// until the result is written to the output register, so one item is in flight.
// The output register holds a result while out_stall is high; the next
// input is taken meanwhile and waits in the write state.
// Reset clears the filter, the sequencer and out_valid.

module multicast_hash_filter_table (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             kind,
	input  wire logic [mhft_pkg::MacBits-1:0]     mac_address,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [mhft_pkg::IdxBits-1:0]     hash_index,
	output logic      [mhft_pkg::TableBits-1:0]   filter_table
);

	mhft_pkg::state_t                  state_q;
	logic                              kind_q;
	logic [mhft_pkg::TableBits-1:0]    hash_bits_q;
	logic                              out_valid_q;
	logic [mhft_pkg::IdxBits-1:0]      idx_q;
	logic [mhft_pkg::TableBits-1:0]    table_out_q;

	mhft_pkg::crc_ctrl_t               crc_ctrl;
	mhft_pkg::crc_stat_t               crc_stat;
	logic [mhft_pkg::IdxBits-1:0]      crc_idx;

	logic                              in_xfer;
	logic                              write_res;
	logic [mhft_pkg::IdxBits-1:0]      idx_next;
	logic [mhft_pkg::TableBits-1:0]    table_next;

	assign in_stall  = (state_q != mhft_pkg::ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	// result slot is free when empty or being drained this cycle
	assign write_res = (state_q == mhft_pkg::ST_WRITE) && (!out_valid_q || !out_stall);

	assign crc_ctrl.load = in_xfer && (kind == mhft_pkg::KindAdd);

	mhft_crc_unit u_crc (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (crc_ctrl),
		.mac_address (mac_address),
		.stat        (crc_stat),
		.hash_index  (crc_idx)
	);

	// clear reports index zero and empties the table
	always_comb begin
		if (kind_q == mhft_pkg::KindAdd) begin
			idx_next   = crc_idx;
			table_next = hash_bits_q | (mhft_pkg::TableBits'(1) << crc_idx);
		end else begin
			idx_next   = '0;
			table_next = '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhft_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				mhft_pkg::ST_IDLE: begin
					if (in_xfer)
						state_q <= (kind == mhft_pkg::KindAdd) ? mhft_pkg::ST_HASH
						                                       : mhft_pkg::ST_WRITE;
				end
				mhft_pkg::ST_HASH: begin
					if (crc_stat.last)
						state_q <= mhft_pkg::ST_WRITE;
				end
				mhft_pkg::ST_WRITE: begin
					if (write_res)
						state_q <= mhft_pkg::ST_IDLE;
				end
				default: state_q <= mhft_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			kind_q <= kind;
	end

	// filter state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_bits_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (write_res) begin
				hash_bits_q <= table_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (write_res) begin
			idx_q       <= idx_next;
			table_out_q <= table_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign hash_index   = idx_q;
	assign filter_table = table_out_q;

	// the CRC engine runs for the whole hash state
	a_hash_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mhft_pkg::ST_HASH |-> crc_stat.busy)
		else $error("hash state without running CRC");

	// the filter changes only on a result write
	a_table_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!write_res |=> $stable(hash_bits_q))
		else $error("filter changed outside a write");

	// an add leaves its bit set in the delivered table
	a_add_sets: assert property (@(posedge clk) disable iff (!arst_n)
		write_res && kind_q == mhft_pkg::KindAdd |=> filter_table[hash_index])
		else $error("added bit missing from filter");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for multicast_hash_filter_table: directed and random add/clear
// transfers, with a shadow CRC-32 hash filter predicting every result. Depends on mhft_pkg.
`timescale 1ns / 100ps

module tb;

	// Own copy of the hash rules; only widths and kind codes come from the package.
	localparam logic [31:0] Crc32Poly  = 32'h04C1_1DB7;
	localparam logic [31:0] Crc32Seed  = 32'hFFFF_FFFF;
	localparam int          IdxLsb     = 26;

	localparam int RandomItems = 1950;
	localparam int PhaseLen    = 200;     // transfers per idling phase
	localparam int HoldAt      = 700;     // transfer count that arms the long output hold-off
	localparam int HoldCycles  = 400;
	localparam int DrainCycles = 60;
	localparam int CycleLimit  = 1000000;

	typedef enum logic [1:0] {
		PH_BUSY,        // nobody idles
		PH_SEND_IDLE,   // sender idle with chance 54 of 100
		PH_RECV_STALL,  // receiver stalls with chance 54 of 100
		PH_BOTH         // both at 6 of 100
	} idle_phase_t;

	typedef struct packed {
		logic                         kind;
		logic [mhft_pkg::MacBits-1:0] mac;
	} filter_cmd_t;

	typedef struct packed {
		logic [mhft_pkg::IdxBits-1:0]   idx;
		logic [mhft_pkg::TableBits-1:0] filt;
	} filter_result_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           in_valid    = 1'b0;
	logic                           kind        = mhft_pkg::KindClear;
	logic [mhft_pkg::MacBits-1:0]   mac_address = '0;
	logic                           out_stall   = 1'b0;
	logic                           in_stall;
	logic                           out_valid;
	logic [mhft_pkg::IdxBits-1:0]   hash_index;
	logic [mhft_pkg::TableBits-1:0] filter_table;

	filter_cmd_t    pending_cmds[$];      // filled up front, drained by the driver
	filter_result_t expected_results[$];  // one entry per accepted transfer

	logic [mhft_pkg::TableBits-1:0] shadow_filter = '0;
	int unsigned                    items_sent    = 0;
	int unsigned                    hold_left     = 0;
	logic                           hold_armed    = 1'b1;
	int unsigned                    cycles        = 0;
	int unsigned                    errors        = 0;
	int unsigned                    results_seen  = 0;
	int unsigned                    adds_done     = 0;
	int unsigned                    adds_repeat   = 0;
	int unsigned                    clears_done   = 0;
	logic [mhft_pkg::TableBits-1:0] bits_ever_set = '0;

	multicast_hash_filter_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.mac_address  (mac_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hash_index   (hash_index),
		.filter_table (filter_table)
	);

	always #5 clk = ~clk;

	// CRC-32 over the address, byte 0 first and each byte LSB first, which is
	// simply bit 0 up to bit 47. MSB-first register, no reflection, no final xor.
	function automatic logic [31:0] mac_crc32(input logic [mhft_pkg::MacBits-1:0] mac);
		logic [31:0] crc;
		logic        fb;
		crc = Crc32Seed;
		for (int i = 0; i < mhft_pkg::MacBits; i++) begin
			fb  = crc[31] ^ mac[i];
			crc = {crc[30:0], 1'b0};
			if (fb)
				crc = crc ^ Crc32Poly;
		end
		return crc;
	endfunction

	// Apply one accepted command to the shadow filter and queue its result.
	task automatic filter_update(input filter_cmd_t cmd);
		filter_result_t res;
		logic [31:0]    crc;
		res.idx = '0;
		if (cmd.kind == mhft_pkg::KindClear) begin
			shadow_filter = '0;
			clears_done++;
		end else begin
			crc     = mac_crc32(cmd.mac);
			res.idx = crc[IdxLsb +: mhft_pkg::IdxBits];
			if (shadow_filter[res.idx])
				adds_repeat++;
			shadow_filter[res.idx] = 1'b1;
			bits_ever_set[res.idx] = 1'b1;
			adds_done++;
		end
		res.filt = shadow_filter;
		expected_results.push_back(res);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at cycle %0d, result %0d: %s got %h expected %h",
			cycles, results_seen, what, got, want);
		errors++;
	endtask

	function automatic idle_phase_t phase_of(input int unsigned n);
		return idle_phase_t'((n / PhaseLen) % 4);
	endfunction

	// Driver: offers the next pending command. A stalled transfer is held as is;
	// otherwise the sender may go idle this cycle depending on the phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin : drive
			filter_cmd_t cmd;
			int unsigned idle_pct;
			case (phase_of(items_sent))
				PH_SEND_IDLE: idle_pct = 54;
				PH_BOTH:      idle_pct = 6;
				default:      idle_pct = 0;
			endcase
			if (in_valid && !in_stall) begin
				cmd.kind = kind;
				cmd.mac  = mac_address;
				filter_update(cmd);
				items_sent <= items_sent + 1;
			end
			if (in_valid && in_stall) begin
				// hold the stalled transfer
			end else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cmd = pending_cmds.pop_front();
				in_valid    <= 1'b1;
				kind        <= cmd.kind;
				mac_address <= cmd.mac;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long output hold-off, armed once: the block takes one more transfer into
	// its write state, then has to stall its input while the sender keeps offering.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_armed <= 1'b1;
		end else if (hold_armed && items_sent >= HoldAt) begin
			hold_left  <= HoldCycles;
			hold_armed <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each result transfer against the oldest expectation and
	// drives out_stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin : watch
			filter_result_t want;
			int unsigned    stall_pct;
			case (phase_of(items_sent))
				PH_RECV_STALL: stall_pct = 54;
				PH_BOTH:       stall_pct = 6;
				default:       stall_pct = 0;
			endcase
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, hash_index", 64'(hash_index), '0);
				end else begin
					want = expected_results.pop_front();
					if (hash_index !== want.idx)
						report_mismatch("hash_index", 64'(hash_index), 64'(want.idx));
					if (filter_table !== want.filt)
						report_mismatch("filter_table", filter_table, want.filt);
				end
				results_seen++;
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycles, expected_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic queue_cmd(input logic k, input logic [mhft_pkg::MacBits-1:0] mac);
		filter_cmd_t cmd;
		cmd.kind = k;
		cmd.mac  = mac;
		pending_cmds.push_back(cmd);
	endtask

	initial begin : stimulus
		logic [63:0]                  r;
		logic [mhft_pkg::MacBits-1:0] mac;
		logic [mhft_pkg::MacBits-1:0] recent[$];
		logic                         k;
		int unsigned                  sel;

		// Directed: address extremes, typical multicast groups, an address added
		// twice, clears that carry an address, a clear of an empty table.
		queue_cmd(mhft_pkg::KindAdd,   48'h0000_0000_0000);
		queue_cmd(mhft_pkg::KindAdd,   48'hFFFF_FFFF_FFFF);
		queue_cmd(mhft_pkg::KindAdd,   48'hFFFF_FFFF_FFFF);
		queue_cmd(mhft_pkg::KindClear, 48'hFFFF_FFFF_FFFF);
		queue_cmd(mhft_pkg::KindAdd,   48'h0000_0000_0001);
		queue_cmd(mhft_pkg::KindAdd,   48'h8000_0000_0000);
		queue_cmd(mhft_pkg::KindAdd,   48'h5555_5555_5555);
		queue_cmd(mhft_pkg::KindAdd,   48'hAAAA_AAAA_AAAA);
		queue_cmd(mhft_pkg::KindAdd,   48'h0100_005E_0001);  // 01:00:5e:00:00:01
		queue_cmd(mhft_pkg::KindAdd,   48'h0100_0000_3333);  // 33:33:00:00:00:01
		queue_cmd(mhft_pkg::KindAdd,   48'hFFFF_FFFF_FFFE);
		queue_cmd(mhft_pkg::KindAdd,   48'h7FFF_FFFF_FFFF);
		queue_cmd(mhft_pkg::KindAdd,   48'h0100_005E_0001);
		queue_cmd(mhft_pkg::KindClear, 48'h0000_0000_0000);
		queue_cmd(mhft_pkg::KindClear, 48'h1234_5678_9ABC);
		queue_cmd(mhft_pkg::KindAdd,   48'h0000_0000_00FF);
		queue_cmd(mhft_pkg::KindAdd,   48'hFF00_0000_0000);
		queue_cmd(mhft_pkg::KindAdd,   48'h0000_0000_0001);

		// Random: the first 400 adds run without a clear so the table fills up;
		// after that a clear now and then. Some adds repeat a recent address or
		// use a single set bit.
		for (int i = 0; i < RandomItems; i++) begin
			r   = {$urandom(), $urandom()};
			mac = r[mhft_pkg::MacBits-1:0];
			k   = mhft_pkg::KindAdd;
			if (i >= 400 && $urandom_range(39) == 0) begin
				k = mhft_pkg::KindClear;
			end else begin
				sel = $urandom_range(7);
				if (sel == 0 && recent.size() != 0) begin
					mac = recent[$urandom_range(recent.size() - 1)];
				end else if (sel == 1) begin
					mac = '0;
					mac[$urandom_range(mhft_pkg::MacBits - 1)] = 1'b1;
				end else if (sel == 2) begin
					mac[0] = 1'b1;  // group address
				end
				recent.push_back(mac);
				if (recent.size() > 16)
					void'(recent.pop_front());
			end
			queue_cmd(k, mac);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		$display("%0d transfers in %0d cycles: %0d adds (%0d to a bit already set), %0d clears",
			items_sent, cycles, adds_done, adds_repeat, clears_done);
		$display("%0d of %0d filter bits set at some point, %0d results checked",
			$countones(bits_ever_set), mhft_pkg::TableBits, results_seen);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
